// ===== src/b64e_pkg.sv =====
// Shared types, constants and the character mapping for the Base64 stream encoder.
// No dependencies; every other file refers to it by scoped names.
package b64e_pkg;

    // Group queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pending byte count codes
    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;   // never reached, handled as two

    // Number of real bytes in a closed group
    localparam logic [1:0] HAVE_ONE   = 2'd1;
    localparam logic [1:0] HAVE_TWO   = 2'd2;
    localparam logic [1:0] HAVE_THREE = 2'd3;

    // Character slot within a group of four
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] SLOT_3 = 2'd3;

    // ASCII anchors of the alphabet
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='

    // One closed group of up to three bytes; missing bytes are zero
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] have;
        logic       fin;
    } grp_t;

    // Six-bit value to its character of the standard alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return CHAR_UPPER_A + v8;
        else if (v < 6'd52)
            return CHAR_LOWER_A + (v8 - 8'd26);
        else if (v < 6'd62)
            return CHAR_DIGIT_0 + (v8 - 8'd52);
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

// ===== src/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: front end, group queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
//   Channel  Direction  Handshake           Fields
//   in       input      in_valid/in_stall   data_byte[7:0], final_byte
//   out      output     out_valid/out_stall out_char[7:0], end_of_text
//
// A byte is taken every cycle while the two-entry group queue has room.
// Each closed group yields four characters, one per cycle through the output
// register while out_stall does not hold it; the single character path of
// the back end sets the sustained rate.
// Reset (rst_n low, asynchronous) empties pending bytes, queue and output.
// in_stall rises only while the queue is full; out_stall freezes the output.
module base64_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       end_of_text
);

    logic           push;
    b64e_pkg::grp_t push_data;
    logic           q_full;
    logic           head_valid;
    b64e_pkg::grp_t head_data;
    logic           pop;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    b64e_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .end_of_text (end_of_text)
    );

endmodule

// ===== src/b64e_front.sv =====
// Front end: accepts bytes, holds up to two pending bytes, closes groups of three
// or at the final byte and pushes them into the group queue. Uses b64e_pkg.
module b64e_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output logic              push,
    output b64e_pkg::grp_t    push_data,
    input  logic              q_full
);

    logic [7:0] p0_reg, p0_next;
    logic [7:0] p1_reg, p1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       in_acc;

    assign in_stall = q_full;
    assign in_acc   = in_valid && !in_stall;

    // Classify the byte: hold it, or close the group
    always_comb
    begin
        p0_next   = p0_reg;
        p1_next   = p1_reg;
        cnt_next  = cnt_reg;
        push      = 1'b0;
        push_data = '0;
        if (in_acc)
        begin
            unique case (cnt_reg) inside
                b64e_pkg::CNT_EMPTY:
                begin
                    if (!final_byte)
                    begin
                        p0_next  = data_byte;
                        cnt_next = b64e_pkg::CNT_ONE;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_data.b0   = data_byte;
                        push_data.have = b64e_pkg::HAVE_ONE;
                    end
                end
                b64e_pkg::CNT_ONE:
                begin
                    if (!final_byte)
                    begin
                        p1_next  = data_byte;
                        cnt_next = b64e_pkg::CNT_TWO;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_data.b0   = p0_reg;
                        push_data.b1   = data_byte;
                        push_data.have = b64e_pkg::HAVE_TWO;
                    end
                end
                b64e_pkg::CNT_TWO, b64e_pkg::CNT_THREE:
                begin
                    push           = 1'b1;
                    push_data.b0   = p0_reg;
                    push_data.b1   = p1_reg;
                    push_data.b2   = data_byte;
                    push_data.have = b64e_pkg::HAVE_THREE;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
            push_data.fin = final_byte;
            if (push)
            begin
                p0_next  = '0;
                p1_next  = '0;
                cnt_next = b64e_pkg::CNT_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg  <= '0;
            p1_reg  <= '0;
            cnt_reg <= b64e_pkg::CNT_EMPTY;
        end
        else
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            cnt_reg <= cnt_next;
        end
    end

    // A final byte always leaves the front empty
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && final_byte |=> cnt_reg == b64e_pkg::CNT_EMPTY)
        else $error("front not empty after final byte");

endmodule

// ===== src/b64e_queue.sv =====
// Short group queue between the front end and the character back end.
// Depth from b64e_pkg::QUEUE_DEPTH; entries are b64e_pkg::grp_t.
module b64e_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64e_pkg::grp_t    push_data,
    output logic              full,
    output logic              head_valid,
    output b64e_pkg::grp_t    head_data,
    input  logic              pop
);

    b64e_pkg::grp_t                   ent_reg [b64e_pkg::QUEUE_DEPTH];
    logic [b64e_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [b64e_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [b64e_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    localparam logic [b64e_pkg::QPTR_W-1:0] PTR_LAST =
        b64e_pkg::QPTR_W'(b64e_pkg::QUEUE_DEPTH - 1);
    localparam logic [b64e_pkg::QCNT_W-1:0] CNT_FULL =
        b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH);

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_data  = ent_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/b64e_back.sv =====
// Back end: walks the head group of the queue, one character per cycle while the
// output register can take it, with padding and end marker. Uses b64e_pkg.
module b64e_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64e_pkg::grp_t    head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_char,
    output logic              end_of_text
);

    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] ch_reg, ch_next;
    logic       eot_reg, eot_next;
    logic       load;
    logic [5:0] sext;
    logic       pad;

    assign out_valid   = ov_reg;
    assign out_char    = ch_reg;
    assign end_of_text = eot_reg;

    // Output register takes a new character when empty or being drained
    assign load = head_valid && (!ov_reg || !out_stall);
    assign pop  = load && (idx_reg == b64e_pkg::SLOT_3);

    // Sextet select and padding decision for the current slot
    always_comb
    begin
        sext = '0;
        pad  = 1'b0;
        unique case (idx_reg)
            b64e_pkg::SLOT_0: sext = head_data.b0[7:2];
            b64e_pkg::SLOT_1: sext = {head_data.b0[1:0], head_data.b1[7:4]};
            b64e_pkg::SLOT_2:
            begin
                sext = {head_data.b1[3:0], head_data.b2[7:6]};
                pad  = (head_data.have == b64e_pkg::HAVE_ONE);
            end
            b64e_pkg::SLOT_3:
            begin
                sext = head_data.b2[5:0];
                pad  = (head_data.have != b64e_pkg::HAVE_THREE);
            end
            default: sext = '0;
        endcase
    end

    // Next values of the slot counter and output register
    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        ch_next  = ch_reg;
        eot_next = eot_reg;
        if (load)
        begin
            idx_next = idx_reg + 1'b1;
            ov_next  = 1'b1;
            ch_next  = pad ? b64e_pkg::CHAR_PAD : b64e_pkg::sextet_char(sext);
            eot_next = head_data.fin && (idx_reg == b64e_pkg::SLOT_3);
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= b64e_pkg::SLOT_0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        eot_reg <= eot_next;
    end

    // The slot counter only advances together with a loaded character
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> idx_reg == $past(idx_reg))
        else $error("slot counter moved without a load");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ov_reg)
        else $error("loaded character not presented");

endmodule
